FILE: hdl/mga_pkg.sv
`default_nettype none
package mga_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W     = 3;
  localparam int SMP_W    = 16;
  localparam int ERR_W    = SMP_W + 1;
  localparam int GAIN_W   = 32;
  localparam int LIM_W    = 31;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;
  // queue depth, must be a power of two
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // shared multiplier operand and product widths
  localparam int MA_W     = 33;
  localparam int MB_W     = 17;
  localparam int PROD_W   = MA_W + MB_W;
  localparam int PART_W   = 48;
  localparam int ACC_W    = 64;
  localparam int UDIFF_W  = 49;
  localparam int U_SHIFT  = 20;

  typedef enum logic {
    REG_ADAPT_GAIN = 1'b0,
    REG_GAIN_LIMIT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0]          ch;
    logic signed [SMP_W-1:0]  r;
    logic signed [SMP_W-1:0]  y;
    logic signed [ERR_W-1:0]  e;
    logic                     ok;
  } item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] adapt_gain;
    logic [LIM_W-1:0]  gain_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RE,
    B_YE,
    B_G1L,
    B_G1H,
    B_G2L,
    B_G2H,
    B_U1,
    B_U2,
    B_U3,
    B_U4,
    B_OUT
  } back_state_t;

  function automatic logic signed [GAIN_W-1:0] clamp_gain(
    input logic signed [GAIN_W:0] v,
    input logic [LIM_W-1:0]       lim
  );
    logic signed [GAIN_W:0] lim_s;
    logic signed [GAIN_W:0] res;
    lim_s = $signed({2'b00, lim});
    if (v > lim_s) begin
      res = lim_s;
    end else if (v < -lim_s) begin
      res = -lim_s;
    end else begin
      res = v;
    end
    return res[GAIN_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/mga_front.sv
`default_nettype none
module mga_front import mga_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_ready,
  input  logic [CH_W-1:0]         channel,
  input  logic signed [SMP_W-1:0] reference,
  input  logic signed [SMP_W-1:0] measured,
  output logic                    push,
  output item_t                   push_item,
  input  logic                    q_full
);

  logic  f_valid;
  logic  f_valid_next;
  item_t f_item;
  logic  take;

  assign push         = f_valid && !q_full;
  assign sample_ready = !f_valid || !q_full;
  assign take         = sample_valid && sample_ready;
  assign push_item    = f_item;

  always_comb begin
    f_valid_next = f_valid;
    if (take) begin
      f_valid_next = 1'b1;
    end else if (push) begin
      f_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  // model error and channel range check are done up front
  always_ff @(posedge clk) begin
    if (take) begin
      f_item.ch <= channel;
      f_item.r  <= reference;
      f_item.y  <= measured;
      f_item.e  <= ERR_W'(measured) - ERR_W'(reference);
      f_item.ok <= (int'(channel) < CHANNELS);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mga_queue.sv
`default_nettype none
module mga_queue import mga_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  item_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mga_back.sv
`default_nettype none
module mga_back import mga_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     q_valid,
  input  item_t                    q_item,
  output logic                     q_pop,
  output logic [CH_W-1:0]          channel_out,
  output logic signed [DATA_W-1:0] drive,
  output logic                     drive_saturated,
  output logic                     result_valid,
  input  logic                     result_ready
);

  back_state_t state;
  back_state_t state_next;
  logic        out_load;

  item_t                     cur;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [GAIN_W-1:0]  p1;
  logic signed [GAIN_W-1:0]  p2;
  logic signed [PART_W-1:0]  acc;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [GAIN_W-1:0]  i1;
  logic signed [GAIN_W-1:0]  i2;
  logic signed [UDIFF_W-1:0] udiff;
  logic signed [GAIN_W-1:0]  ff_gain [CHANNELS];
  logic signed [GAIN_W-1:0]  fb_gain [CHANNELS];

  logic signed [ACC_W-1:0]   part_sum;
  logic signed [GAIN_W-1:0]  term;
  logic signed [GAIN_W:0]    ff_upd;
  logic signed [GAIN_W:0]    fb_upd;
  logic signed [UDIFF_W-U_SHIFT-1:0] ushift;
  logic signed [DATA_W+1:0]  uext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = q_item.ok ? B_RE : B_OUT;
        end
      end
      B_RE:  state_next = B_YE;
      B_YE:  state_next = B_G1L;
      B_G1L: state_next = B_G1H;
      B_G1H: state_next = B_G2L;
      B_G2L: state_next = B_G2H;
      B_G2H: state_next = B_U1;
      B_U1:  state_next = B_U2;
      B_U2:  state_next = B_U3;
      B_U3:  state_next = B_U4;
      B_U4:  state_next = B_OUT;
      B_OUT: begin
        if (!result_valid || result_ready) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // one shared 33x17 multiplier; the gain factor goes in as two 16-bit halves
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      B_RE: begin
        mul_a = MA_W'(cur.e);
        mul_b = MB_W'(cur.r);
      end
      B_YE: begin
        mul_a = MA_W'(cur.e);
        mul_b = MB_W'(cur.y);
      end
      B_G1L: begin
        mul_a = MA_W'(p1);
        mul_b = $signed({1'b0, cfg.adapt_gain[15:0]});
      end
      B_G1H: begin
        mul_a = MA_W'(p1);
        mul_b = $signed({1'b0, cfg.adapt_gain[31:16]});
      end
      B_G2L: begin
        mul_a = MA_W'(p2);
        mul_b = $signed({1'b0, cfg.adapt_gain[15:0]});
      end
      B_G2H: begin
        mul_a = MA_W'(p2);
        mul_b = $signed({1'b0, cfg.adapt_gain[31:16]});
      end
      B_U1: begin
        mul_a = MA_W'(i1);
        mul_b = MB_W'(cur.r);
      end
      B_U3: begin
        mul_a = MA_W'(i2);
        mul_b = MB_W'(cur.y);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // high partial product shifted up by 16 plus the low one
  assign part_sum = $signed({prod[PART_W-1:0], 16'h0000}) + ACC_W'(acc);
  // floor of the Q8.56 update term down to Q8.24
  assign term     = $signed(acc_sum[ACC_W-1:ACC_W-GAIN_W]);
  assign ff_upd   = (GAIN_W+1)'(ff_gain[cur.ch]) - (GAIN_W+1)'(term);
  assign fb_upd   = (GAIN_W+1)'(fb_gain[cur.ch]) + (GAIN_W+1)'(term);
  assign ushift   = $signed(udiff[UDIFF_W-1:U_SHIFT]);
  assign uext     = (DATA_W+2)'(ushift);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (q_pop) begin
      cur <= q_item;
    end
    case (state)
      B_YE:  p1      <= prod[GAIN_W-1:0];
      B_G1L: p2      <= prod[GAIN_W-1:0];
      B_G1H: acc     <= prod[PART_W-1:0];
      B_G2L: acc_sum <= part_sum;
      B_G2H: begin
        acc <= prod[PART_W-1:0];
        i1  <= clamp_gain(ff_upd, cfg.gain_limit);
      end
      B_U1:  acc_sum <= part_sum;
      B_U2: begin
        acc <= prod[PART_W-1:0];
        i2  <= clamp_gain(fb_upd, cfg.gain_limit);
      end
      B_U4:  udiff <= UDIFF_W'(acc) - UDIFF_W'($signed(prod[PART_W-1:0]));
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ff_gain[i] <= '0;
        fb_gain[i] <= '0;
      end
    end else begin
      if (state == B_U1) begin
        ff_gain[cur.ch] <= i1;
      end
      if (state == B_U3) begin
        fb_gain[cur.ch] <= i2;
      end
    end
  end

  // output register, so the next item can start while this one waits
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= out_load || (result_valid && !result_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      channel_out <= cur.ch;
      if (!cur.ok) begin
        drive           <= '0;
        drive_saturated <= 1'b0;
      end else if (uext > (DATA_W+2)'(34'sh0_7FFF_FFFF)) begin
        drive           <= 32'sh7FFF_FFFF;
        drive_saturated <= 1'b1;
      end else if (uext < -(DATA_W+2)'(34'sh0_8000_0000)) begin
        drive           <= $signed(32'h8000_0000);
        drive_saturated <= 1'b1;
      end else begin
        drive           <= uext[DATA_W-1:0];
        drive_saturated <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mrac_gradient_adaptation.sv
// path: front register, queue, then the 12-state back sequencer; the front and
//   queue keep taking samples while the sequencer works on an earlier one
// sequencing: the back sequencer takes one sample at a time and runs all
//   six products and the drive difference through one shared 33x17 multiplier
// reset: synchronous, active high; clears all adaptive gains to zero, empties the
//   queue, sets adapt_gain to 0 and gain_limit to 0x7fffffff
`default_nettype none
module mrac_gradient_adaptation import mga_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     sample_valid,
  output logic                     sample_ready,
  input  logic [CH_W-1:0]          channel,
  input  logic signed [SMP_W-1:0]  reference,
  input  logic signed [SMP_W-1:0]  measured,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic [CH_W-1:0]          channel_out,
  output logic signed [DATA_W-1:0] drive,
  output logic                     drive_saturated
);

  logic [GAIN_W-1:0] adapt_gain;
  logic [LIM_W-1:0]  gain_limit;
  cfg_t              cfg;
  reg_idx_t          reg_idx;
  logic              wr_en;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  item_t q_item;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      adapt_gain <= '0;
      gain_limit <= '1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ADAPT_GAIN: adapt_gain <= pwdata;
        REG_GAIN_LIMIT: gain_limit <= pwdata[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ADAPT_GAIN: prdata = adapt_gain;
      REG_GAIN_LIMIT: prdata = {1'b0, gain_limit};
      default:        prdata = '0;
    endcase
  end

  assign cfg.adapt_gain = adapt_gain;
  assign cfg.gain_limit = gain_limit;

  mga_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .channel      (channel),
    .reference    (reference),
    .measured     (measured),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  mga_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  mga_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .channel_out     (channel_out),
    .drive           (drive),
    .drive_saturated (drive_saturated),
    .result_valid    (result_valid),
    .result_ready    (result_ready)
  );

  // the front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("queue overflow");

  // the back only pops a non-empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue underflow");

  // a clipped drive sits at one of the two rails
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    (result_valid && drive_saturated) |->
      (drive == 32'sh7FFF_FFFF || drive == $signed(32'h8000_0000)))
    else $error("saturated drive off rail");

  // no result is left pending out of reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire
